/* design/assert_macros.svh */
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* design/ilb_pkg.sv */
`timescale 1ns / 1ps

package ilb_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 9;
  localparam int OPCODE_W     = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET      = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

/* design/ilb_cell.sv */
`timescale 1ns / 1ps

module ilb_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  ilb_pkg::cell_ctrl_t       ctrl,
  input  logic [ilb_pkg::DATA_W-1:0] left,
  input  logic [ilb_pkg::DATA_W-1:0] right,
  output logic [ilb_pkg::DATA_W-1:0] data,
  output logic [ilb_pkg::DATA_W-1:0] tap
);
  import ilb_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

  logic hit;
  logic above;

  assign hit   = (ctrl.pos == MY_POS);
  assign above = (MY_POS > ctrl.pos);

  // Contents are meaningful only below the list length, so no reset.
  always_ff @(posedge clk) begin
    if (ctrl.ins && hit) begin
      data <= ctrl.value;
    end else if (ctrl.ins && above) begin
      data <= left;
    end else if (ctrl.del && (hit || above)) begin
      data <= right;
    end
  end

  // Only the addressed cell drives the read bus.
  assign tap = hit ? data : '0;

endmodule

/* design/ilb_decode.sv */
`timescale 1ns / 1ps

module ilb_decode #(
  parameter int CAPACITY = ilb_pkg::DEF_CAPACITY,
  parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
  input  logic                        accept,
  input  logic [ilb_pkg::OPCODE_W-1:0] opcode,
  input  logic [7:0]                  position,
  input  logic [ilb_pkg::DATA_W-1:0]  item_value,
  input  logic [LEN_W-1:0]            count,
  output ilb_pkg::cell_ctrl_t         ctrl,
  output ilb_pkg::status_t            status,
  output logic                        get_ok,
  output logic [LEN_W-1:0]            count_next
);
  import ilb_pkg::*;

  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  logic [POS_W-1:0] pos_ext;
  logic [POS_W-1:0] cnt_ext;
  logic             full;
  logic             in_range;

  assign pos_ext  = POS_W'(position);
  assign cnt_ext  = POS_W'(count);
  assign full     = (cnt_ext >= CAP_POS);
  assign in_range = (pos_ext < cnt_ext);

  always_comb begin
    ctrl       = '0;
    ctrl.value = item_value;
    status     = ST_DONE;
    get_ok     = 1'b0;
    count_next = count;
    case (opcode_t'(opcode))
      OP_GET: begin
        // The position also selects which cell drives the read bus.
        ctrl.pos = pos_ext;
        if (in_range) begin
          get_ok = 1'b1;
        end else begin
          status = ST_BAD;
        end
      end
      OP_INS_HEAD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins = accept;
          ctrl.pos = '0;
        end
      end
      OP_INS_TAIL: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins = accept;
          ctrl.pos = cnt_ext;
        end
      end
      OP_INS_AT: begin
        if (pos_ext > cnt_ext) begin
          status = ST_BAD;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins = accept;
          ctrl.pos = pos_ext;
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          ctrl.del = accept;
          ctrl.pos = pos_ext;
        end else begin
          status = ST_BAD;
        end
      end
      default: begin
        status = ST_BAD;
      end
    endcase
    if (status == ST_DONE) begin
      if (opcode_t'(opcode) == OP_DELETE) begin
        count_next = count - LEN_W'(1);
      end else if (opcode_t'(opcode) != OP_GET) begin
        count_next = count + LEN_W'(1);
      end
    end
  end

endmodule

/* design/indexed_list_buffer.sv */
`timescale 1ns / 1ps
// A result item appears in the cycle after its input item is accepted.
// One item per cycle while the result is not stalled; the whole chain of cells shifts at once.
// An item is accepted while the result register is empty or being taken.
// Reset clears the list length and the result valid; cell contents are kept
// and are never read before they are written.

module indexed_list_buffer #(
  parameter int CAPACITY = ilb_pkg::DEF_CAPACITY,
  parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [ilb_pkg::OPCODE_W-1:0] opcode,
  input  logic [7:0]                   position,
  input  logic signed [ilb_pkg::DATA_W-1:0] item_value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [ilb_pkg::DATA_W-1:0] read_value,
  output logic [ilb_pkg::STATUS_W-1:0] status,
  output logic [LEN_W-1:0]             list_length
);
  import ilb_pkg::*;

  // The list lives in a row of cells, one entry per cell, cell 0 holding the
  // head. An insert moves every entry from the position on one place up, a
  // delete moves every entry above the position one place down.
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_tap  [CAPACITY];
  logic [DATA_W-1:0] read_bus;

  logic [LEN_W-1:0]  count;
  logic [LEN_W-1:0]  count_next;
  logic              accept;
  cell_ctrl_t        ctrl;
  status_t           dec_status;
  logic              get_ok;

  // The result register frees itself in the same cycle it is taken.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  ilb_decode #(
    .CAPACITY (CAPACITY),
    .LEN_W    (LEN_W)
  ) u_decode (
    .accept     (accept),
    .opcode     (opcode),
    .position   (position),
    .item_value (item_value),
    .count      (count),
    .ctrl       (ctrl),
    .status     (dec_status),
    .get_ok     (get_ok),
    .count_next (count_next)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    // The ends of the chain never feed a used entry, so they take zero.
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i+1];
    end

    ilb_cell #(
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  // Each cell gates its entry onto the bus only when it is addressed, so the
  // bus is a plain OR of the taps.
  always_comb begin
    read_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_bus = read_bus | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload; a get that fails, and every other operation, reads all ones.
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value  <= get_ok ? read_bus : '1;
      status      <= dec_status;
      list_length <= count_next;
    end
  end

endmodule

/* design/ilb_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ilb_checker #(
  parameter int CAPACITY = ilb_pkg::DEF_CAPACITY,
  parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input logic [ilb_pkg::OPCODE_W-1:0] opcode,
  input logic [7:0]                   position,
  input logic [ilb_pkg::DATA_W-1:0]   item_value,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [ilb_pkg::DATA_W-1:0]   read_value,
  input logic [ilb_pkg::STATUS_W-1:0] status,
  input logic [LEN_W-1:0]             list_length
);
  import ilb_pkg::*;

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

  // A waiting result blocks new items only while it is stalled.
  `ASSERT_RUN(a_stall_link, (item_stall == (result_valid && result_stall)), "input stall mismatch")

  // A dropped insert can only come from a full list.
  `ASSERT_RUN(a_full_len, (result_valid && status == ST_FULL) |-> (list_length == LEN_W'(CAPACITY)), "full status below capacity")

  // A rejected operation never returns data.
  `ASSERT_RUN(a_bad_value, (result_valid && status == ST_BAD) |-> (read_value == '1), "bad status with data")

  // A stalled result holds its payload.
  `ASSERT_RUN(a_hold, (result_valid && result_stall) |=> (result_valid && $stable(read_value)), "stalled result changed")

endmodule

bind indexed_list_buffer ilb_checker #(
  .CAPACITY (CAPACITY),
  .LEN_W    (LEN_W)
) u_ilb_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

// Checks the positional list buffer against a predictor that holds its own copy
// of the list. Every accepted item is pushed through the predictor and the
// expected result is queued; every result taken from the block is compared
// with the oldest queued result, field by field.

module tb;
  import ilb_pkg::*;

  localparam int CAP         = DEF_CAPACITY;
  localparam int LEN_W       = $clog2(CAP + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MAX   = 40;

  // One expected result: the value read, the status and the length afterward.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           code;
    logic [LEN_W-1:0]  len;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     item_valid   = 1'b0;
  logic                     item_stall;
  logic [OPCODE_W-1:0]      opcode       = '0;
  logic [7:0]               position     = '0;
  logic signed [DATA_W-1:0] item_value   = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;
  logic [LEN_W-1:0]         list_length;

  indexed_list_buffer #(
    .CAPACITY(CAP)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .opcode      (opcode),
    .position    (position),
    .item_value  (item_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .read_value  (read_value),
    .status      (status),
    .list_length (list_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the list, updated as each item is accepted.
  logic [DATA_W-1:0] shadow_list [CAP];
  int                shadow_len = 0;
  list_result_t      pending_results [$];

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_done    = 0;
  int n_bad     = 0;
  int n_full    = 0;
  int peak_len  = 0;
  int cycles    = 0;

  // Idling controls. The sender and the receiver each draw a random wait per
  // item while their flag is set. A test can also ask the receiver for one
  // long hold-off through hold_len.
  bit sender_gaps = 1'b1;
  bit reply_gaps  = 1'b1;
  int hold_len    = 0;
  int stall_left  = 0;

  // Makes room at position p and writes the new value there; everything at
  // and above p moves up one place.
  task automatic open_gap(input int p, input logic [DATA_W-1:0] val);
    for (int i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[p] = val;
    shadow_len++;
  endtask

  task automatic predict_outcome(input logic [OPCODE_W-1:0] op, input logic [7:0] pos,
                                 input logic [DATA_W-1:0] val);
    list_result_t r;
    int p;
    r.value = '1;
    r.code  = ST_DONE;
    p       = int'(pos);
    case (op)
      OP_GET: begin
        if (p < shadow_len) r.value = shadow_list[p];
        else r.code = ST_BAD;
      end
      OP_INS_HEAD: begin
        if (shadow_len >= CAP) r.code = ST_FULL;
        else open_gap(0, val);
      end
      OP_INS_TAIL: begin
        if (shadow_len >= CAP) r.code = ST_FULL;
        else open_gap(shadow_len, val);
      end
      OP_INS_AT: begin
        // A position past the end is rejected before fullness is looked at.
        if (p > shadow_len) r.code = ST_BAD;
        else if (shadow_len >= CAP) r.code = ST_FULL;
        else open_gap(p, val);
      end
      OP_DELETE: begin
        if (p < shadow_len) begin
          for (int i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
        end else begin
          r.code = ST_BAD;
        end
      end
      default: r.code = ST_BAD;
    endcase
    r.len = shadow_len[LEN_W-1:0];
    pending_results.push_back(r);
    case (r.code)
      ST_DONE: n_done++;
      ST_BAD:  n_bad++;
      default: n_full++;
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
  endtask

  // Offers one item after a random gap and returns once the block has taken
  // it. Valid is left high, so the next call either replaces the payload at
  // the next falling edge or lowers valid there.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [7:0] pos,
                           input logic [DATA_W-1:0] val);
    int gap;
    gap = sender_gaps ? $urandom_range(9, 0) : 0;
    repeat (gap) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    opcode     <= op;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (item_stall);
    n_sent++;
    predict_outcome(op, pos, val);
  endtask

  // Lowers valid once a test has no more items to offer.
  task automatic park_sender();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  // Picks one random operation. The list drifts toward the target length:
  // inserts win while it is shorter, deletes once it has reached it. Most
  // positions are in range for the current length; the rest are anywhere in
  // the 8-bit field. A few items carry an undefined opcode.
  task automatic send_random_item(input int target);
    logic [OPCODE_W-1:0] op;
    logic [7:0] pos;
    int roll;
    bit grow;
    roll = $urandom_range(99, 0);
    if (roll < 4) begin
      op = OPCODE_W'($urandom_range(7, 5));
    end else if (roll < 24) begin
      op = OP_GET;
    end else begin
      grow = (shadow_len < target) ? ($urandom_range(99, 0) < 75)
                                   : ($urandom_range(99, 0) < 25);
      if (!grow) op = OP_DELETE;
      else begin
        case ($urandom_range(2, 0))
          0:       op = OP_INS_HEAD;
          1:       op = OP_INS_TAIL;
          default: op = OP_INS_AT;
        endcase
      end
    end
    if ($urandom_range(99, 0) < 15) pos = 8'($urandom_range(255, 0));
    else if (op == OP_INS_AT) pos = 8'($urandom_range(shadow_len, 0));
    else if (shadow_len == 0) pos = '0;
    else pos = 8'($urandom_range(shadow_len - 1, 0));
    send_item(op, pos, $urandom());
  endtask

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    errors++;
    if (errors <= SHOWN_MAX)
      $display("%0t ns: %s mismatch on result %0d: got %h, expected %h",
               $time, what, n_checked, got, want);
  endtask

  // Receiver stall. A long hold-off request replaces whatever wait is left;
  // otherwise the wait drawn after the last result runs down one per cycle.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      stall_left = hold_len;
      hold_len   = 0;
    end
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Result checker: every result taken is matched against the oldest
  // expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, length", DATA_W'(list_length), '0);
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.value) flag_mismatch("read_value", read_value, want.value);
        if (status !== want.code)
          flag_mismatch("status", DATA_W'(status), DATA_W'(want.code));
        if (list_length !== want.len)
          flag_mismatch("list_length", DATA_W'(list_length), DATA_W'(want.len));
      end
      n_checked++;
      stall_left = reply_gaps ? $urandom_range(9, 0) : 0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycles, pending_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Directed corners: operations on an empty list, each kind of insert
  // including an append through insert-at with the position equal to the
  // length, extreme data values, reads and deletes at the ends and beyond,
  // and the three undefined opcodes.
  task automatic test_edge_cases();
    // Empty list: nothing can be read, deleted, or inserted past the end.
    send_item(OP_GET, 8'd0, '0);
    send_item(OP_DELETE, 8'd0, '0);
    send_item(OP_INS_AT, 8'd1, 32'h1234_5678);
    // Insert-at with the position equal to the length works on an empty list.
    send_item(OP_INS_AT, 8'd0, 32'h5A5A_A5A5);
    send_item(OP_INS_HEAD, 8'd255, 32'h8000_0000);
    send_item(OP_INS_TAIL, 8'd255, 32'h7FFF_FFFF);
    // An all-ones value must read back as data, not as the no-value marker.
    send_item(OP_INS_AT, 8'd1, 32'hFFFF_FFFF);
    send_item(OP_INS_AT, 8'd4, 32'h0000_0000);
    send_item(OP_GET, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_GET, 8'd4, '0);
    send_item(OP_GET, 8'd1, '0);
    send_item(OP_GET, 8'd5, '0);
    send_item(OP_GET, 8'd255, '0);
    send_item(OP_INS_AT, 8'd255, 32'hDEAD_BEEF);
    send_item(OP_DELETE, 8'd255, '0);
    send_item(OP_DELETE, 8'd1, '0);
    send_item(OP_DELETE, 8'd3, '0);
    send_item(OP_GET, 8'd2, '0);
    // Undefined opcodes change nothing.
    send_item(3'd5, 8'd255, 32'hFFFF_FFFF);
    send_item(3'd6, 8'd0, 32'h0000_0001);
    send_item(3'd7, 8'd170, 32'hAAAA_5555);
    send_item(OP_GET, 8'd0, '0);
    park_sender();
  endtask

  // Fills the list to capacity, then checks that every insert is dropped,
  // that a position past the end is still reported as bad rather than full,
  // and that one delete makes room for exactly one insert. The list is then
  // emptied again by deletes at random positions.
  task automatic test_full_list();
    logic [OPCODE_W-1:0] op;
    while (shadow_len < CAP) begin
      case ($urandom_range(2, 0))
        0:       op = OP_INS_HEAD;
        1:       op = OP_INS_TAIL;
        default: op = OP_INS_AT;
      endcase
      send_item(op, 8'($urandom_range(shadow_len, 0)), $urandom());
    end
    send_item(OP_INS_HEAD, 8'd0, $urandom());
    send_item(OP_INS_TAIL, 8'd0, $urandom());
    send_item(OP_INS_AT, 8'(CAP), $urandom());
    send_item(OP_INS_AT, 8'(CAP + 1), $urandom());
    send_item(OP_INS_AT, 8'd255, $urandom());
    send_item(OP_GET, 8'(CAP - 1), '0);
    send_item(OP_GET, 8'(CAP), '0);
    send_item(OP_DELETE, 8'(CAP), '0);
    send_item(OP_DELETE, 8'(CAP - 1), '0);
    send_item(OP_INS_AT, 8'(CAP - 1), 32'hC0DE_0001);
    send_item(OP_INS_AT, 8'd0, $urandom());
    send_item(OP_GET, 8'(CAP - 1), '0);
    while (shadow_len > 0) send_item(OP_DELETE, 8'($urandom_range(shadow_len - 1, 0)), '0);
    send_item(OP_DELETE, 8'd0, '0);
    park_sender();
  endtask

  // The receiver holds off for a long stretch while the sender offers items
  // back to back, so the result register fills and the block stalls its
  // input with a payload waiting.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_len    = 150;
    repeat (40) send_random_item(32);
    park_sender();
    sender_gaps = 1'b1;
  endtask

  // Random operations in blocks, each block steering the length toward a
  // different target so the list spends time empty, short, mid-sized and
  // full. One block runs with no idling on either side.
  task automatic test_random_mix();
    int targets [7];
    targets = '{4, CAP, 12, CAP, 0, 40, CAP};
    for (int b = 0; b < 7; b++) begin
      sender_gaps = (b != 3);
      reply_gaps  = (b != 3);
      repeat (80) send_random_item(targets[b]);
    end
    sender_gaps = 1'b1;
    reply_gaps  = 1'b1;
    park_sender();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_full_list();
    test_backpressure();
    test_random_mix();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d items sent, %0d results checked, longest list %0d of %0d",
             n_sent, n_checked, peak_len, CAP);
    $display("summary: %0d completed, %0d rejected for position or opcode, %0d dropped as full",
             n_done, n_bad, n_full);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
